// File: src/stack_positional_edit_engine_assert.svh
`ifndef STACK_POSITIONAL_EDIT_ENGINE_ASSERT_SVH
`define STACK_POSITIONAL_EDIT_ENGINE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SPEE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define SPEE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/spee_pkg.sv
package spee_pkg;

  localparam int unsigned DEPTH_DEF = 128;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned POS_W     = 8;
  localparam int unsigned COUNT_W   = 8;

  localparam logic [KIND_W-1:0] KIND_PUSH   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SWAP   = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_INS_RD,
    ST_INS_WR,
    ST_INS_PUT,
    ST_SWP_RDA,
    ST_SWP_RDB,
    ST_SWP_WRA,
    ST_SWP_WRB,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    logic [POS_W-1:0]  pos_a;
    logic [POS_W-1:0]  pos_b;
  } cmd_t;

  typedef struct packed {
    logic               valid;
    logic               found;
    logic               status;
    logic [COUNT_W-1:0] count;
  } res_t;

endpackage

// File: src/spee_if.sv
interface spee_in_if;
  logic                              valid;
  logic                              ready;
  logic [spee_pkg::KIND_W-1:0]       kind;
  logic signed [spee_pkg::KEY_W-1:0] key;
  logic [spee_pkg::POS_W-1:0]        pos_a;
  logic [spee_pkg::POS_W-1:0]        pos_b;

  modport source (output valid, kind, key, pos_a, pos_b, input ready);
  modport sink (input valid, kind, key, pos_a, pos_b, output ready);
endinterface

interface spee_out_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic                          status;
  logic [spee_pkg::COUNT_W-1:0]  count;

  modport source (output valid, found, status, count, input ready);
  modport sink (input valid, found, status, count, output ready);
endinterface

// File: src/spee_ram.sv
module spee_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/spee_ctrl.sv
module spee_ctrl #(
  parameter int unsigned DEPTH = spee_pkg::DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  spee_pkg::cmd_t             cmd_i,
  output logic                       ready_o,
  output spee_pkg::res_t             res_o,
  input  logic                       take_i,
  output logic                       ram_we_o,
  output logic [$clog2(DEPTH)-1:0]   ram_waddr_o,
  output logic [spee_pkg::KEY_W-1:0] ram_wdata_o,
  output logic                       ram_re_o,
  output logic [$clog2(DEPTH)-1:0]   ram_raddr_o,
  input  logic [spee_pkg::KEY_W-1:0] ram_rdata_i
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PW = ((CW > spee_pkg::POS_W) ? CW : spee_pkg::POS_W) + 1;

  spee_pkg::state_e state_q, state_d;

  logic [spee_pkg::KIND_W-1:0] kind_q, kind_d;
  logic [spee_pkg::KEY_W-1:0]  key_q, key_d;
  logic [spee_pkg::POS_W-1:0]  pa_q, pa_d;
  logic [spee_pkg::POS_W-1:0]  pb_q, pb_d;
  logic [CW-1:0]               count_q, count_d;
  logic [AW-1:0]               idx_q, idx_d;
  logic [AW-1:0]               idx2_q, idx2_d;
  logic [spee_pkg::KEY_W-1:0]  tmp_q, tmp_d;
  logic                        found_q, found_d;
  logic                        status_q, status_d;

  logic [PW-1:0] cnt_w, pa_w, pb_w, idx_w, slot_w;
  logic          full, ins_bad, swp_bad;
  logic          step_up;
  logic [AW-1:0] idx_adj;

  assign cnt_w  = PW'(count_q);
  assign pa_w   = PW'(pa_q);
  assign pb_w   = PW'(pb_q);
  assign idx_w  = PW'(idx_q);
  assign slot_w = cnt_w + PW'(1) - pa_w;

  assign full    = (count_q == CW'(DEPTH));
  assign ins_bad = full || (pa_q == '0) || (pa_w > cnt_w + PW'(1));
  assign swp_bad = (pa_q == '0) || (pb_q == '0) || (pa_w > cnt_w) || (pb_w > cnt_w)
                   || (pa_q == pb_q);

  // the one index stepper: up while closing a gap after delete, down otherwise
  assign step_up = (state_q == spee_pkg::ST_DEL_RD) || (state_q == spee_pkg::ST_DEL_WR);
  assign idx_adj = step_up ? (idx_q + AW'(1)) : (idx_q - AW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= spee_pkg::ST_IDLE;
      count_q  <= '0;
      found_q  <= 1'b0;
      status_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      found_q  <= found_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    key_q  <= key_d;
    pa_q   <= pa_d;
    pb_q   <= pb_d;
    idx_q  <= idx_d;
    idx2_q <= idx2_d;
    tmp_q  <= tmp_d;
  end

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    key_d       = key_q;
    pa_d        = pa_q;
    pb_d        = pb_q;
    count_d     = count_q;
    idx_d       = idx_q;
    idx2_d      = idx2_q;
    tmp_d       = tmp_q;
    found_d     = found_q;
    status_d    = status_q;
    ready_o     = 1'b0;
    res_o       = '0;
    ram_we_o    = 1'b0;
    ram_waddr_o = idx_q;
    ram_wdata_o = key_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = idx_q;

    unique case (state_q)
      spee_pkg::ST_IDLE: begin
        ready_o = 1'b1;
        if (cmd_i.valid) begin
          kind_d   = cmd_i.kind;
          key_d    = cmd_i.key;
          pa_d     = cmd_i.pos_a;
          pb_d     = cmd_i.pos_b;
          found_d  = 1'b0;
          status_d = 1'b0;
          state_d  = spee_pkg::ST_DECODE;
        end
      end

      spee_pkg::ST_DECODE: begin
        state_d = spee_pkg::ST_DONE;
        unique case (kind_q) inside
          spee_pkg::KIND_PUSH: begin
            if (full) begin
              status_d = 1'b1;
            end else begin
              ram_we_o    = 1'b1;
              ram_waddr_o = count_q[AW-1:0];
              count_d     = count_q + CW'(1);
            end
          end
          spee_pkg::KIND_QUERY, spee_pkg::KIND_DELETE: begin
            if (count_q != '0) begin
              idx_d   = count_q[AW-1:0] - AW'(1);
              state_d = spee_pkg::ST_SCAN_RD;
            end
          end
          spee_pkg::KIND_INSERT: begin
            if (ins_bad) begin
              status_d = 1'b1;
            end else begin
              idx_d   = count_q[AW-1:0];
              idx2_d  = slot_w[AW-1:0];
              // inserting at the top needs no shift
              state_d = (pa_q == spee_pkg::POS_W'(1)) ? spee_pkg::ST_INS_PUT
                                                      : spee_pkg::ST_INS_RD;
            end
          end
          spee_pkg::KIND_SWAP: begin
            if (swp_bad) begin
              status_d = 1'b1;
            end else begin
              idx_d   = AW'(cnt_w - pa_w);
              idx2_d  = AW'(cnt_w - pb_w);
              state_d = spee_pkg::ST_SWP_RDA;
            end
          end
          default: begin
            status_d = 1'b1;
          end
        endcase
      end

      spee_pkg::ST_SCAN_RD: begin
        ram_re_o = 1'b1;
        state_d  = spee_pkg::ST_SCAN_CMP;
      end

      spee_pkg::ST_SCAN_CMP: begin
        if (ram_rdata_i == key_q) begin
          found_d = 1'b1;
          state_d = spee_pkg::ST_DONE;
          if (kind_q == spee_pkg::KIND_DELETE) begin
            if (idx_w + PW'(1) < cnt_w) begin
              state_d = spee_pkg::ST_DEL_RD;
            end else begin
              count_d = count_q - CW'(1);
            end
          end
        end else if (idx_q == '0) begin
          state_d = spee_pkg::ST_DONE;
        end else begin
          idx_d   = idx_adj;
          state_d = spee_pkg::ST_SCAN_RD;
        end
      end

      spee_pkg::ST_DEL_RD: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = idx_adj;
        state_d     = spee_pkg::ST_DEL_WR;
      end

      spee_pkg::ST_DEL_WR: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = ram_rdata_i;
        idx_d       = idx_adj;
        if (idx_w + PW'(2) < cnt_w) begin
          state_d = spee_pkg::ST_DEL_RD;
        end else begin
          count_d = count_q - CW'(1);
          state_d = spee_pkg::ST_DONE;
        end
      end

      spee_pkg::ST_INS_RD: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = idx_adj;
        state_d     = spee_pkg::ST_INS_WR;
      end

      spee_pkg::ST_INS_WR: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = ram_rdata_i;
        idx_d       = idx_adj;
        state_d     = (idx_adj == idx2_q) ? spee_pkg::ST_INS_PUT : spee_pkg::ST_INS_RD;
      end

      spee_pkg::ST_INS_PUT: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = idx2_q;
        count_d     = count_q + CW'(1);
        state_d     = spee_pkg::ST_DONE;
      end

      spee_pkg::ST_SWP_RDA: begin
        ram_re_o = 1'b1;
        state_d  = spee_pkg::ST_SWP_RDB;
      end

      spee_pkg::ST_SWP_RDB: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = idx2_q;
        tmp_d       = ram_rdata_i;
        state_d     = spee_pkg::ST_SWP_WRA;
      end

      spee_pkg::ST_SWP_WRA: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = ram_rdata_i;
        state_d     = spee_pkg::ST_SWP_WRB;
      end

      spee_pkg::ST_SWP_WRB: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = idx2_q;
        ram_wdata_o = tmp_q;
        state_d     = spee_pkg::ST_DONE;
      end

      spee_pkg::ST_DONE: begin
        res_o.valid  = 1'b1;
        res_o.found  = found_q;
        res_o.status = status_q;
        res_o.count  = spee_pkg::COUNT_W'(count_q);
        if (take_i) begin
          state_d = spee_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = spee_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: src/stack_positional_edit_engine.sv
// one item at a time: ready is low from acceptance until its result is in the output register
// push, rejected items, unknown kinds and query or delete on an empty stack: decode, then done
// query and delete scan down from the top entry, a read state then a compare state per entry;
// a delete that hits below the top then closes the gap, reading and writing each entry above;
// insert shifts entries above its slot up; swap reads, then writes both; the ram has one port pair
// reset clears the controller state, count, found/status flags and output valid; the entry ram is not cleared
module stack_positional_edit_engine #(
  parameter int unsigned DEPTH = spee_pkg::DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  spee_in_if.sink           item_i,
  spee_out_if.source        result_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  spee_pkg::cmd_t cmd;
  spee_pkg::res_t res;
  logic           ctrl_ready;
  logic           take;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [spee_pkg::KEY_W-1:0] ram_wdata;
  logic                       ram_re;
  logic [AW-1:0]              ram_raddr;
  logic [spee_pkg::KEY_W-1:0] ram_rdata;

  logic                         out_valid_q;
  logic                         out_found_q;
  logic                         out_status_q;
  logic [spee_pkg::COUNT_W-1:0] out_count_q;

  assign cmd.valid = item_i.valid;
  assign cmd.kind  = item_i.kind;
  assign cmd.key   = item_i.key;
  assign cmd.pos_a = item_i.pos_a;
  assign cmd.pos_b = item_i.pos_b;
  assign item_i.ready = ctrl_ready;

  // the output register takes a result when empty or being drained
  assign take = res.valid && (!out_valid_q || result_o.ready);

  spee_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .ready_o     (ctrl_ready),
    .res_o       (res),
    .take_i      (take),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  spee_ram #(
    .WIDTH(spee_pkg::KEY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_found_q  <= res.found;
      out_status_q <= res.status;
      out_count_q  <= res.count;
    end
  end

  assign result_o.valid  = out_valid_q;
  assign result_o.found  = out_found_q;
  assign result_o.status = out_status_q;
  assign result_o.count  = out_count_q;

endmodule

// File: src/spee_checker.sv
`include "stack_positional_edit_engine_assert.svh"

module spee_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic                         found_i,
  input logic                         status_i,
  input logic [spee_pkg::COUNT_W-1:0] count_i
);

  // a stalled result keeps its value
  `SPEE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(found_i) && $stable(status_i) && $stable(count_i), "result changed while stalled")

  // the block works on one item at a time
  `SPEE_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "item taken while busy")

  // a rejected item never reports a hit
  `SPEE_ASSERT_SAME(a_reject_no_found, clk_i, rst_ni, out_valid_i && status_i, !found_i, "rejected result with found set")

endmodule

bind stack_positional_edit_engine spee_checker u_spee_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .found_i     (result_o.found),
  .status_i    (result_o.status),
  .count_i     (result_o.count)
);

// File: tb/stack_positional_edit_engine_test.sv
`timescale 1ns / 100ps

module stack_positional_edit_engine_test;

  localparam int unsigned DEPTH = spee_pkg::DEPTH_DEF;
  localparam int unsigned KIND_W = spee_pkg::KIND_W;
  localparam int unsigned KEY_W = spee_pkg::KEY_W;
  localparam int unsigned POS_W = spee_pkg::POS_W;
  localparam int unsigned COUNT_W = spee_pkg::COUNT_W;
  localparam int unsigned POS_TOP = DEPTH + 1;
  localparam int unsigned RANDOM_ITEMS = 1930;
  localparam logic [KIND_W-1:0] KIND_MAX = '1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    logic [POS_W-1:0]  pos_a;
    logic [POS_W-1:0]  pos_b;
  } edit_item_t;

  typedef struct packed {
    logic               found;
    logic               status;
    logic [COUNT_W-1:0] count;
  } edit_result_t;

  typedef struct {
    logic [KEY_W-1:0] slot [DEPTH];
    int unsigned      used;
  } key_stack_t;

  typedef enum int unsigned {
    DRIFT_GROW,
    DRIFT_MIX,
    DRIFT_SHRINK
  } drift_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  spee_in_if  item_if ();
  spee_out_if result_if ();

  stack_positional_edit_engine #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if),
    .result_o(result_if)
  );

  edit_item_t   pending_q [$];
  edit_result_t expected_q [$];
  key_stack_t   plan_stack;
  key_stack_t   check_stack;
  int unsigned  sent_cnt;
  int unsigned  taken_cnt;
  int unsigned  err_cnt;
  int unsigned  in_gap;
  int unsigned  in_quiet;
  int unsigned  out_stall;
  int unsigned  out_quiet;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // applies one edit to a stack image and returns the result it produces
  function automatic edit_result_t apply_edit(inout key_stack_t s, input edit_item_t it);
    edit_result_t     r;
    int               hit;
    int unsigned      i;
    int unsigned      slot_idx;
    int unsigned      ia;
    int unsigned      ib;
    logic [KEY_W-1:0] tmp;
    r = '0;
    hit = -1;
    for (i = s.used; i > 0; i--) begin
      if (hit < 0 && s.slot[i-1] == it.key) hit = i - 1;
    end
    case (it.kind)
      spee_pkg::KIND_PUSH: begin
        if (s.used >= DEPTH) begin
          r.status = 1'b1;
        end else begin
          s.slot[s.used] = it.key;
          s.used++;
        end
      end
      spee_pkg::KIND_QUERY: r.found = (hit >= 0);
      spee_pkg::KIND_INSERT: begin
        if (s.used >= DEPTH || it.pos_a == 0 || it.pos_a > s.used + 1) begin
          r.status = 1'b1;
        end else begin
          slot_idx = s.used + 1 - it.pos_a;
          for (i = s.used; i > slot_idx; i--) s.slot[i] = s.slot[i-1];
          s.slot[slot_idx] = it.key;
          s.used++;
        end
      end
      spee_pkg::KIND_DELETE: begin
        if (hit >= 0) begin
          for (i = hit; i + 1 < s.used; i++) s.slot[i] = s.slot[i+1];
          s.used--;
          r.found = 1'b1;
        end
      end
      spee_pkg::KIND_SWAP: begin
        if (it.pos_a == 0 || it.pos_b == 0 || it.pos_a > s.used || it.pos_b > s.used ||
            it.pos_a == it.pos_b) begin
          r.status = 1'b1;
        end else begin
          ia = s.used - it.pos_a;
          ib = s.used - it.pos_b;
          tmp = s.slot[ia];
          s.slot[ia] = s.slot[ib];
          s.slot[ib] = tmp;
        end
      end
      default: r.status = 1'b1;
    endcase
    r.count = s.used[COUNT_W-1:0];
    return r;
  endfunction

  // mostly short gaps, a few long ones, and now and then a quiet stretch
  function automatic int unsigned pick_gap(inout int unsigned quiet);
    int unsigned roll;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      quiet = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return $urandom;
    if (roll < 70) return $urandom_range(0, 7);
    if (roll < 85) return -$urandom_range(1, 8);
    case ($urandom_range(0, 3))
      0: return {1'b1, {(KEY_W-1){1'b0}}};
      1: return {1'b0, {(KEY_W-1){1'b1}}};
      2: return '1;
      default: return '0;
    endcase
  endfunction

  // key already on the planned stack, or a fresh one
  function automatic logic [KEY_W-1:0] held_key(int unsigned pct);
    if (plan_stack.used > 0 && $urandom_range(0, 99) < pct)
      return plan_stack.slot[$urandom_range(0, plan_stack.used - 1)];
    return rand_key();
  endfunction

  task automatic add_item(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                          logic [POS_W-1:0] pos_a, logic [POS_W-1:0] pos_b);
    edit_item_t   it;
    edit_result_t dummy;
    it = '{kind: kind, key: key, pos_a: pos_a, pos_b: pos_b};
    dummy = apply_edit(plan_stack, it);
    pending_q.push_back(it);
  endtask

  // input side: present the next pending item after a random gap
  always @(negedge clk_i) begin
    edit_item_t it;
    if (rst_ni) begin
      if (!(item_if.valid && taken_cnt != sent_cnt)) begin
        if (in_gap > 0) begin
          in_gap--;
          item_if.valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          it = pending_q.pop_front();
          item_if.kind  <= it.kind;
          item_if.key   <= it.key;
          item_if.pos_a <= it.pos_a;
          item_if.pos_b <= it.pos_b;
          item_if.valid <= 1'b1;
          sent_cnt++;
          in_gap = pick_gap(in_quiet);
        end else begin
          item_if.valid <= 1'b0;
        end
      end
    end
  end

  // result side stalls
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_stall > 0) begin
        out_stall--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
        out_stall = pick_gap(out_quiet);
      end
    end
  end

  always @(posedge clk_i) begin
    edit_item_t   it;
    edit_result_t want;
    if (rst_ni) begin
      if (item_if.valid && item_if.ready) begin
        it = '{kind: item_if.kind, key: item_if.key, pos_a: item_if.pos_a,
               pos_b: item_if.pos_b};
        expected_q.push_back(apply_edit(check_stack, it));
        taken_cnt++;
      end
      if (result_if.valid && result_if.ready) begin
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: found %0b status %0b count %0d",
                 result_if.found, result_if.status, result_if.count);
          err_cnt++;
        end else begin
          want = expected_q.pop_front();
          if (result_if.found !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, result_if.found);
            err_cnt++;
          end
          if (result_if.status !== want.status) begin
            $error("status: expected %0b, got %0b", want.status, result_if.status);
            err_cnt++;
          end
          if (result_if.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, result_if.count);
            err_cnt++;
          end
        end
      end
    end
  end

  initial begin
    #(20_000_000);
    $display("FAIL stack_positional_edit_engine");
    $finish;
  end

  initial begin
    drift_e            drift;
    int unsigned       phase;
    int unsigned       left;
    int unsigned       n;
    int unsigned       roll;
    int unsigned       used;
    int unsigned       w_push;
    int unsigned       w_ins;
    int unsigned       w_qry;
    int unsigned       w_del;
    logic [POS_W-1:0]  pa;
    logic [POS_W-1:0]  pb;

    rst_ni = 1'b0;
    item_if.valid = 1'b0;
    item_if.kind = spee_pkg::KIND_PUSH;
    item_if.key = '0;
    item_if.pos_a = '0;
    item_if.pos_b = '0;
    result_if.ready = 1'b0;
    sent_cnt = 0;
    taken_cnt = 0;
    err_cnt = 0;
    in_gap = 0;
    in_quiet = 0;
    out_stall = 0;
    out_quiet = 0;
    plan_stack.used = 0;
    check_stack.used = 0;

    // empty stack corner cases
    add_item(spee_pkg::KIND_QUERY, '0, 0, 0);
    add_item(spee_pkg::KIND_DELETE, '0, 0, 0);
    add_item(spee_pkg::KIND_SWAP, '0, 1, 2);
    add_item(spee_pkg::KIND_INSERT, '0, 0, 0);
    add_item(spee_pkg::KIND_INSERT, '0, 2, 0);
    add_item(spee_pkg::KIND_INSERT, {1'b1, {(KEY_W-1){1'b0}}}, 1, 0);
    add_item(spee_pkg::KIND_PUSH, {1'b0, {(KEY_W-1){1'b1}}}, 0, 0);
    add_item(spee_pkg::KIND_PUSH, '1, 0, 0);
    // insert at the bottom, then in the middle
    add_item(spee_pkg::KIND_INSERT, '0, 4, 0);
    add_item(spee_pkg::KIND_INSERT, 32'h0000_0001, 2, 0);
    add_item(spee_pkg::KIND_QUERY, {1'b1, {(KEY_W-1){1'b0}}}, 0, 0);
    add_item(spee_pkg::KIND_QUERY, 32'h1234_5678, 0, 0);
    add_item(spee_pkg::KIND_SWAP, '0, 1, 5);
    add_item(spee_pkg::KIND_SWAP, '0, 2, 2);
    add_item(spee_pkg::KIND_SWAP, '0, 0, 1);
    add_item(spee_pkg::KIND_SWAP, '0, 1, 6);
    add_item(spee_pkg::KIND_SWAP, '0, POS_W'(POS_TOP), POS_W'(POS_TOP));
    add_item(spee_pkg::KIND_INSERT, '0, POS_W'(POS_TOP), 0);
    add_item(spee_pkg::KIND_DELETE, '1, 0, 0);
    add_item(spee_pkg::KIND_DELETE, 32'h5555_5555, 0, 0);
    add_item(spee_pkg::KIND_PUSH, {1'b0, {(KEY_W-1){1'b1}}}, 0, 0);
    add_item(spee_pkg::KIND_DELETE, {1'b0, {(KEY_W-1){1'b1}}}, 0, 0);
    add_item(spee_pkg::KIND_SWAP + 3'd1, '1, 1, 2);
    add_item(KIND_MAX - 3'd1, '0, 1, 2);
    add_item(KIND_MAX, '0, 0, 0);

    // random part drifts between filling, mixed and draining phases
    phase = 0;
    drift = DRIFT_GROW;
    left = 300;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (left == 0) begin
        phase++;
        case (phase % 4)
          0: drift = DRIFT_GROW;
          2: drift = DRIFT_SHRINK;
          default: drift = DRIFT_MIX;
        endcase
        left = $urandom_range(120, 260);
      end
      left--;
      used = plan_stack.used;
      case (drift)
        DRIFT_GROW: begin
          w_push = 45; w_ins = 75; w_qry = 85; w_del = 93;
        end
        DRIFT_SHRINK: begin
          w_push = 10; w_ins = 18; w_qry = 30; w_del = 85;
        end
        default: begin
          w_push = 20; w_ins = 40; w_qry = 60; w_del = 80;
        end
      endcase
      if ($urandom_range(0, 99) < 6) begin
        add_item(KIND_W'($urandom_range(0, KIND_MAX)), $urandom,
                 POS_W'($urandom_range(0, POS_TOP)), POS_W'($urandom_range(0, POS_TOP)));
      end else begin
        roll = $urandom_range(0, 99);
        pb = POS_W'($urandom_range(0, POS_TOP));
        if (roll < w_push) begin
          add_item(spee_pkg::KIND_PUSH, rand_key(), POS_W'($urandom_range(0, POS_TOP)), pb);
        end else if (roll < w_ins) begin
          if ($urandom_range(0, 99) < 85) pa = POS_W'($urandom_range(1, used + 1));
          else pa = POS_W'($urandom_range(0, POS_TOP));
          add_item(spee_pkg::KIND_INSERT, rand_key(), pa, pb);
        end else if (roll < w_qry) begin
          add_item(spee_pkg::KIND_QUERY, held_key(60), POS_W'($urandom_range(0, POS_TOP)), pb);
        end else if (roll < w_del) begin
          add_item(spee_pkg::KIND_DELETE, held_key(75), POS_W'($urandom_range(0, POS_TOP)),
                   pb);
        end else begin
          if (used >= 2 && $urandom_range(0, 99) < 85) begin
            pa = POS_W'($urandom_range(1, used));
            pb = POS_W'($urandom_range(1, used - 1));
            if (pb >= pa) pb++;
          end else begin
            pa = POS_W'($urandom_range(0, POS_TOP));
            if ($urandom_range(0, 3) == 0) pb = pa;
          end
          add_item(spee_pkg::KIND_SWAP, rand_key(), pa, pb);
        end
      end
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_q.size() != 0 || taken_cnt != sent_cnt || expected_q.size() != 0)
      @(posedge clk_i);
    repeat (2 * DEPTH + 20) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      $error("%0d results still expected", expected_q.size());
      err_cnt++;
    end

    if (err_cnt == 0) begin
      $display("PASS stack_positional_edit_engine");
    end else begin
      $display("FAIL stack_positional_edit_engine");
    end
    $finish;
  end

endmodule
